>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// Filled shape rasterizer package
// Frame geometry, payload types, opcodes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int FRAME_SIDE = 32;
    localparam int SIDE_W     = $clog2(FRAME_SIDE);
    localparam int PIXELS     = FRAME_SIDE * FRAME_SIDE;
    localparam int ADDR_W     = $clog2(PIXELS);
    localparam int PIX_W      = 32;

    // Shape edges and disc centres span -256..382
    localparam int COORD_W = 11;
    // Squared offsets stay below 2^18, radius squared below 2^14
    localparam int SQ_W    = 18;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ACC_W   = SQ_W + 2;
    localparam int RSQ_W   = 14;

    localparam logic signed [COORD_W-1:0] SIDE_COORD = COORD_W'(FRAME_SIDE);

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_RECT   = 3'd1,
        OP_CIRCLE = 3'd2,
        OP_ROUND  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [7:0]        box_width;
        logic [7:0]        box_height;
        logic [6:0]        radius;
        logic [7:0]        paint_red;
        logic [7:0]        paint_green;
        logic [7:0]        paint_blue;
        logic [7:0]        paint_alpha;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
    } pixel_t;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_PREP,
        ST_DRAW,
        ST_READ,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic prep;
        logic sweep_draw;
        logic sweep_clear;
        logic read_issue;
        logic read_capture;
        logic push;
    } ctrl_t;

    typedef struct packed {
        logic       sweep_last;
        logic       out_free;
        logic [2:0] op;
    } stat_t;

endpackage

>>> hw/rtl/fsr_frame_store.sv
// ----------------------------------------------------------------------------
// Frame store
// FRAME_SIDE x FRAME_SIDE RGBA pixel memory, one write and one registered read.
// ----------------------------------------------------------------------------
module fsr_frame_store (
    input  logic                       clk,
    input  logic                       we,
    input  logic [fsr_pkg::ADDR_W-1:0] waddr,
    input  logic [fsr_pkg::PIX_W-1:0]  wdata,
    input  logic                       re,
    input  logic [fsr_pkg::ADDR_W-1:0] raddr,
    output logic [fsr_pkg::PIX_W-1:0]  rdata
);

    logic [fsr_pkg::PIX_W-1:0] mem [fsr_pkg::PIXELS];
    logic [fsr_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/fsr_datapath.sv
// ----------------------------------------------------------------------------
// Rasterizer datapath
// Command register, shape setup, raster sweep counters with incremental
// squared offsets, coverage test, frame store and result/output registers.
// ----------------------------------------------------------------------------
module fsr_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  fsr_pkg::cmd_t   cmd_data,
    input  fsr_pkg::ctrl_t  ctrl,
    output fsr_pkg::stat_t  stat,
    input  logic            out_ready,
    output logic            out_valid,
    output fsr_pkg::pixel_t out_data
);

    localparam int CW = fsr_pkg::COORD_W;
    localparam int SW = fsr_pkg::SIDE_W;

    function automatic logic [fsr_pkg::SQ_W-1:0] sq_coord(input logic signed [CW-1:0] v);
        logic signed [2*CW-1:0] p;
        begin
            p = v * v;
            return p[fsr_pkg::SQ_W-1:0];
        end
    endfunction

    // (d+1)^2 = d^2 + 2d + 1
    function automatic logic [fsr_pkg::SQ_W-1:0] sq_step(
        input logic [fsr_pkg::SQ_W-1:0] sq,
        input logic signed [CW-1:0]     d
    );
        logic [fsr_pkg::ACC_W-1:0] acc;
        begin
            acc = {{(fsr_pkg::ACC_W-fsr_pkg::SQ_W){1'b0}}, sq}
                + ({{(fsr_pkg::ACC_W-CW){d[CW-1]}}, d} << 1)
                + fsr_pkg::ACC_W'(1);
            return acc[fsr_pkg::SQ_W-1:0];
        end
    endfunction

    function automatic logic in_disc(
        input logic [fsr_pkg::SQ_W-1:0]  sqx,
        input logic [fsr_pkg::SQ_W-1:0]  sqy,
        input logic [fsr_pkg::RSQ_W-1:0] rsq
    );
        logic [fsr_pkg::SUM_W-1:0] s;
        begin
            s = {1'b0, sqx} + {1'b0, sqy};
            return s <= fsr_pkg::SUM_W'(rsq);
        end
    endfunction

    fsr_pkg::cmd_t   cmd_reg;
    fsr_pkg::pixel_t result_reg;
    fsr_pkg::pixel_t out_data_reg;
    logic            out_valid_reg;

    logic [SW-1:0]              px_reg;
    logic [SW-1:0]              py_reg;
    logic [fsr_pkg::ADDR_W-1:0] addr_reg;

    logic signed [CW-1:0] bax0_reg, bax1_reg, bay0_reg, bay1_reg;
    logic signed [CW-1:0] bbx0_reg, bbx1_reg, bby0_reg, bby1_reg;
    logic                 ba_en_reg, bb_en_reg;
    logic [3:0]           disc_en_reg;
    logic signed [CW-1:0] cxa_reg, cxb_reg, cya_reg, cyb_reg;

    logic [fsr_pkg::SQ_W-1:0]  cxa_sq_reg, cxb_sq_reg;
    logic [fsr_pkg::SQ_W-1:0]  sqxa_reg, sqxb_reg, sqya_reg, sqyb_reg;
    logic [fsr_pkg::RSQ_W-1:0] rsq_reg;

    // Setup values
    logic signed [CW-1:0] x_e, y_e, w_e, h_e, r_e, r2_e;
    logic signed [CW-1:0] bax0_next, bax1_next, bay0_next, bay1_next;
    logic signed [CW-1:0] bbx0_next, bbx1_next, bby0_next, bby1_next;
    logic                 ba_en_next, bb_en_next;
    logic [3:0]           disc_en_next;
    logic signed [CW-1:0] cxa_next, cxb_next, cya_next, cyb_next;

    // Sweep values
    logic                 last_col, last_row;
    logic signed [CW-1:0] pxs, pys;
    logic signed [CW-1:0] dxa, dxb, dya, dyb;
    logic                 box_a, box_b;
    logic [3:0]           disc_hit;
    logic                 covered;

    logic                       we;
    logic [fsr_pkg::PIX_W-1:0]  wdata;
    logic [fsr_pkg::ADDR_W-1:0] raddr;
    logic [fsr_pkg::PIX_W-1:0]  rdata;
    logic                       read_in_frame;
    fsr_pkg::pixel_t            read_pixel;

    assign x_e  = {{(CW-8){cmd_reg.pos_x[7]}}, cmd_reg.pos_x};
    assign y_e  = {{(CW-8){cmd_reg.pos_y[7]}}, cmd_reg.pos_y};
    assign w_e  = {{(CW-8){1'b0}}, cmd_reg.box_width};
    assign h_e  = {{(CW-8){1'b0}}, cmd_reg.box_height};
    assign r_e  = {{(CW-7){1'b0}}, cmd_reg.radius};
    assign r2_e = r_e + r_e;

    always_comb
    begin
        bax0_next    = x_e;
        bax1_next    = x_e + w_e;
        bay0_next    = y_e;
        bay1_next    = y_e + h_e;
        bbx0_next    = x_e;
        bbx1_next    = x_e + w_e;
        bby0_next    = y_e + r_e;
        bby1_next    = y_e + h_e - r_e;
        ba_en_next   = 1'b0;
        bb_en_next   = 1'b0;
        disc_en_next = 4'b0000;
        cxa_next     = x_e;
        cxb_next     = x_e;
        cya_next     = y_e;
        cyb_next     = y_e;
        unique case (cmd_reg.op)
            fsr_pkg::OP_RECT:
            begin
                ba_en_next = (w_e > 0) && (h_e > 0);
            end
            fsr_pkg::OP_CIRCLE:
            begin
                disc_en_next = 4'b0001;
            end
            fsr_pkg::OP_ROUND:
            begin
                // Cross boxes, then corner discs at x+r and x+w-r-1
                bax0_next    = x_e + r_e;
                bax1_next    = x_e + w_e - r_e;
                ba_en_next   = ((w_e - r2_e) > 0) && (h_e > 0);
                bb_en_next   = (w_e > 0) && ((h_e - r2_e) > 0);
                disc_en_next = 4'b1111;
                cxa_next     = x_e + r_e;
                cxb_next     = x_e + w_e - r_e - CW'(1);
                cya_next     = y_e + r_e;
                cyb_next     = y_e + h_e - r_e - CW'(1);
            end
            default:
            begin
                ba_en_next = 1'b0;
            end
        endcase
    end

    assign last_col = (px_reg == SW'(fsr_pkg::FRAME_SIDE - 1));
    assign last_row = (py_reg == SW'(fsr_pkg::FRAME_SIDE - 1));

    assign pxs = $signed({{(CW-SW){1'b0}}, px_reg});
    assign pys = $signed({{(CW-SW){1'b0}}, py_reg});
    assign dxa = pxs - cxa_reg;
    assign dxb = pxs - cxb_reg;
    assign dya = pys - cya_reg;
    assign dyb = pys - cyb_reg;

    assign box_a = ba_en_reg && (pxs >= bax0_reg) && (pxs < bax1_reg)
                 && (pys >= bay0_reg) && (pys < bay1_reg);
    assign box_b = bb_en_reg && (pxs >= bbx0_reg) && (pxs < bbx1_reg)
                 && (pys >= bby0_reg) && (pys < bby1_reg);

    assign disc_hit[0] = disc_en_reg[0] && in_disc(sqxa_reg, sqya_reg, rsq_reg);
    assign disc_hit[1] = disc_en_reg[1] && in_disc(sqxb_reg, sqya_reg, rsq_reg);
    assign disc_hit[2] = disc_en_reg[2] && in_disc(sqxa_reg, sqyb_reg, rsq_reg);
    assign disc_hit[3] = disc_en_reg[3] && in_disc(sqxb_reg, sqyb_reg, rsq_reg);

    assign covered = box_a || box_b || (disc_hit != 4'b0000);

    // Sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            addr_reg <= '0;
        end
        else if (ctrl.sweep_draw || ctrl.sweep_clear)
        begin
            if (last_col)
            begin
                px_reg <= '0;
                py_reg <= last_row ? '0 : py_reg + SW'(1);
            end
            else
            begin
                px_reg <= px_reg + SW'(1);
            end
            addr_reg <= (last_col && last_row) ? '0 : addr_reg + fsr_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd_data;
        end
        if (ctrl.setup)
        begin
            bax0_reg    <= bax0_next;
            bax1_reg    <= bax1_next;
            bay0_reg    <= bay0_next;
            bay1_reg    <= bay1_next;
            bbx0_reg    <= bbx0_next;
            bbx1_reg    <= bbx1_next;
            bby0_reg    <= bby0_next;
            bby1_reg    <= bby1_next;
            ba_en_reg   <= ba_en_next;
            bb_en_reg   <= bb_en_next;
            disc_en_reg <= disc_en_next;
            cxa_reg     <= cxa_next;
            cxb_reg     <= cxb_next;
            cya_reg     <= cya_next;
            cyb_reg     <= cyb_next;
        end
        if (ctrl.prep)
        begin
            // Offsets at pixel (0,0) are minus the centre
            cxa_sq_reg <= sq_coord(cxa_reg);
            cxb_sq_reg <= sq_coord(cxb_reg);
            sqxa_reg   <= sq_coord(cxa_reg);
            sqxb_reg   <= sq_coord(cxb_reg);
            sqya_reg   <= sq_coord(cya_reg);
            sqyb_reg   <= sq_coord(cyb_reg);
            rsq_reg    <= fsr_pkg::RSQ_W'(cmd_reg.radius) * fsr_pkg::RSQ_W'(cmd_reg.radius);
        end
        else if (ctrl.sweep_draw)
        begin
            if (last_col)
            begin
                sqxa_reg <= cxa_sq_reg;
                sqxb_reg <= cxb_sq_reg;
                sqya_reg <= sq_step(sqya_reg, dya);
                sqyb_reg <= sq_step(sqyb_reg, dyb);
            end
            else
            begin
                sqxa_reg <= sq_step(sqxa_reg, dxa);
                sqxb_reg <= sq_step(sqxb_reg, dxb);
            end
        end
        if (ctrl.load)
        begin
            result_reg <= '0;
        end
        else if (ctrl.read_capture)
        begin
            result_reg <= read_in_frame ? read_pixel : '0;
        end
        if (ctrl.push)
        begin
            out_data_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign we    = ctrl.sweep_clear || (ctrl.sweep_draw && covered);
    assign wdata = ctrl.sweep_clear ? '0
                 : {cmd_reg.paint_alpha, cmd_reg.paint_blue,
                    cmd_reg.paint_green, cmd_reg.paint_red};

    assign read_in_frame = (x_e >= 0) && (x_e < fsr_pkg::SIDE_COORD)
                         && (y_e >= 0) && (y_e < fsr_pkg::SIDE_COORD);
    assign raddr = fsr_pkg::ADDR_W'(cmd_reg.pos_y[SW-1:0]) * fsr_pkg::ADDR_W'(fsr_pkg::FRAME_SIDE)
                 + fsr_pkg::ADDR_W'(cmd_reg.pos_x[SW-1:0]);

    assign read_pixel.pixel_red   = rdata[7:0];
    assign read_pixel.pixel_green = rdata[15:8];
    assign read_pixel.pixel_blue  = rdata[23:16];
    assign read_pixel.pixel_alpha = rdata[31:24];

    fsr_frame_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (wdata),
        .re    (ctrl.read_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.sweep_last = last_col && last_row;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.op         = cmd_reg.op;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/fsr_controller.sv
// ----------------------------------------------------------------------------
// Rasterizer controller
// Sequences reset clearing, command decode, setup, raster sweeps, pixel
// reads and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module fsr_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  fsr_pkg::stat_t stat,
    output fsr_pkg::ctrl_t ctrl
);

    fsr_pkg::state_t state_reg;
    fsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsr_pkg::ST_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            fsr_pkg::ST_INIT_CLR:
            begin
                ctrl.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = fsr_pkg::ST_IDLE;
                end
            end
            fsr_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = fsr_pkg::ST_DECODE;
                end
            end
            fsr_pkg::ST_DECODE:
            begin
                ctrl.setup = 1'b1;
                unique case (stat.op) inside
                    fsr_pkg::OP_CLEAR:
                        state_next = fsr_pkg::ST_CLEAR;
                    fsr_pkg::OP_RECT, fsr_pkg::OP_CIRCLE, fsr_pkg::OP_ROUND:
                        state_next = fsr_pkg::ST_PREP;
                    fsr_pkg::OP_READ:
                        state_next = fsr_pkg::ST_READ;
                    default:
                        state_next = fsr_pkg::ST_FINISH;
                endcase
            end
            fsr_pkg::ST_CLEAR:
            begin
                ctrl.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = fsr_pkg::ST_FINISH;
                end
            end
            fsr_pkg::ST_PREP:
            begin
                ctrl.prep  = 1'b1;
                state_next = fsr_pkg::ST_DRAW;
            end
            fsr_pkg::ST_DRAW:
            begin
                ctrl.sweep_draw = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = fsr_pkg::ST_FINISH;
                end
            end
            fsr_pkg::ST_READ:
            begin
                ctrl.read_issue = 1'b1;
                state_next      = fsr_pkg::ST_READ_WAIT;
            end
            fsr_pkg::ST_READ_WAIT:
            begin
                ctrl.read_capture = 1'b1;
                state_next        = fsr_pkg::ST_FINISH;
            end
            fsr_pkg::ST_FINISH:
            begin
                // Hold until the output register can take the result
                if (stat.out_free)
                begin
                    ctrl.push  = 1'b1;
                    state_next = fsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/filled_shape_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// Filled shape rasterizer unit
// Clear, rect, circle and rounded-rect fills plus pixel reads over an RGBA
// frame store.
//
//   Channel  Signals                           Carries
//   cmd      cmd_valid, cmd_ready, cmd_data    one command (fsr_pkg::cmd_t)
//   pixel    pixel_valid, pixel_ready,         one result per command
//            pixel_data                        (fsr_pkg::pixel_t)
//
// Each fill sweeps the whole frame between transfer and result: the sweep
// visits one pixel per cycle on the single write port of the store. Clear
// sweeps the whole frame as well. After reset a clearing pass runs with
// cmd_ready low. A new command transfers while a result waits in the output
// register; the finished command then holds until that register drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module filled_shape_rasterizer_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  fsr_pkg::cmd_t   cmd_data,
    output logic            pixel_valid,
    input  logic            pixel_ready,
    output fsr_pkg::pixel_t pixel_data
);

    fsr_pkg::ctrl_t ctrl;
    fsr_pkg::stat_t stat;

    fsr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    fsr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_ready (pixel_ready),
        .out_valid (pixel_valid),
        .out_data  (pixel_data)
    );

    `ASSERT_CLK(a_ready_no_sweep, cmd_ready |-> !(ctrl.sweep_draw || ctrl.sweep_clear), "ready during sweep")
    `ASSERT_CLK(a_busy_after_transfer, (cmd_valid && cmd_ready) |=> !cmd_ready, "ready right after transfer")
    `ASSERT_CLK(a_push_free, ctrl.push |-> stat.out_free, "result pushed into full output register")
    `ASSERT_CLK(a_valid_from_push, $rose(pixel_valid) |-> $past(ctrl.push), "result valid without push")

endmodule

>>> dv/filled_shape_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filled shape rasterizer unit testbench
// Runs a table of directed commands, then random commands and draw-and-probe sequences.
// A local frame image predicts each pixel result that the table does not fix, and each result transfer
// is checked in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module filled_shape_rasterizer_unit_tb;

    localparam int         SIDE         = fsr_pkg::FRAME_SIDE;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int         RANDOM_ITEMS = 425;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         CYCLE_LIMIT  = 2_000_000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    typedef struct {
        fsr_pkg::cmd_t   cmd;
        bit              known;
        fsr_pkg::pixel_t want;
    } cmd_row_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cmd_valid   = 1'b0;
    logic            cmd_ready;
    fsr_pkg::cmd_t   cmd_data    = '0;
    logic            pixel_valid;
    logic            pixel_ready = 1'b0;
    fsr_pkg::pixel_t pixel_data;

    fsr_pkg::pixel_t frame_img [SIDE*SIDE];
    fsr_pkg::pixel_t pending_pixels [$];
    cmd_row_t        directed_rows [$];
    string           lane_names [4] = '{"alpha", "blue", "green", "red"};
    bit              note_known;
    fsr_pkg::pixel_t note_want;
    int              error_count = 0;
    int              cycle_count = 0;
    int              burst_left  = 0;
    int              ready_left  = 0;
    rx_mode_t        ready_mode  = RX_OPEN;

    filled_shape_rasterizer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_data  (pixel_data)
    );

    always #2 clk = ~clk;

    function automatic bit in_box(int px, int py, int x, int y, int w, int h);
        return w > 0 && h > 0 && px >= x && px < x + w && py >= y && py < y + h;
    endfunction

    function automatic bit in_disc(int px, int py, int cx, int cy, int r);
        return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
    endfunction

    function automatic bit shape_covers(logic [2:0] op, int px, int py, int x, int y,
                                        int w, int h, int r);
        int xr;
        int yb;
        xr = x + w - r - 1;
        yb = y + h - r - 1;
        case (op)
            fsr_pkg::OP_RECT:   return in_box(px, py, x, y, w, h);
            fsr_pkg::OP_CIRCLE: return in_disc(px, py, x, y, r);
            default:            return in_box(px, py, x + r, y, w - 2 * r, h) ||
                                       in_box(px, py, x, y + r, w, h - 2 * r) ||
                                       in_disc(px, py, x + r, y + r, r) ||
                                       in_disc(px, py, xr, y + r, r) ||
                                       in_disc(px, py, x + r, yb, r) ||
                                       in_disc(px, py, xr, yb, r);
        endcase
    endfunction

    // Apply one command to the frame image and return the pixel it answers with
    function automatic fsr_pkg::pixel_t rasterize_cmd(fsr_pkg::cmd_t c);
        int              x, y, w, h, r;
        fsr_pkg::pixel_t paint;
        fsr_pkg::pixel_t pix;
        x     = int'($signed(c.pos_x));
        y     = int'($signed(c.pos_y));
        w     = int'(c.box_width);
        h     = int'(c.box_height);
        r     = int'(c.radius);
        paint = {c.paint_red, c.paint_green, c.paint_blue, c.paint_alpha};
        pix   = '0;
        case (c.op) inside
            fsr_pkg::OP_CLEAR:
                foreach (frame_img[i]) frame_img[i] = '0;
            fsr_pkg::OP_RECT, fsr_pkg::OP_CIRCLE, fsr_pkg::OP_ROUND:
                for (int py = 0; py < SIDE; py++)
                    for (int px = 0; px < SIDE; px++)
                        if (shape_covers(c.op, px, py, x, y, w, h, r))
                            frame_img[py*SIDE + px] = paint;
            fsr_pkg::OP_READ:
                if (x >= 0 && x < SIDE && y >= 0 && y < SIDE)
                    pix = frame_img[y*SIDE + x];
            default: ;
        endcase
        return pix;
    endfunction

    function automatic fsr_pkg::cmd_t make_cmd(logic [2:0] op, int x, int y, int w, int h,
                                               int r, logic [31:0] rgba);
        fsr_pkg::cmd_t c;
        c.op         = op;
        c.pos_x      = 8'(x);
        c.pos_y      = 8'(y);
        c.box_width  = 8'(w);
        c.box_height = 8'(h);
        c.radius     = 7'(r);
        {c.paint_red, c.paint_green, c.paint_blue, c.paint_alpha} = rgba;
        return c;
    endfunction

    function automatic void add_row(fsr_pkg::cmd_t c, bit known, logic [31:0] want);
        directed_rows.push_back('{c, known, fsr_pkg::pixel_t'(want)});
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_cmd(fsr_pkg::cmd_t c, bit known, fsr_pkg::pixel_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_valid  <= 1'b1;
        cmd_data   <= c;
        note_known = known;
        note_want  = want;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    // Receiver stalls in phases of random length, each with its own pattern
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = rx_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 256);
        end
        ready_left--;
        case (ready_mode)
            RX_OPEN:   pixel_ready <= 1'b1;
            RX_COIN:   pixel_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: pixel_ready <= ($urandom_range(0, 3) == 0);
            default:   pixel_ready <= ready_left[2];
        endcase
    end

    always @(posedge clk)
    begin : result_check
        fsr_pkg::pixel_t shade;
        fsr_pkg::pixel_t want;
        logic [3:0][7:0] got_lanes;
        logic [3:0][7:0] want_lanes;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                shade = rasterize_cmd(cmd_data);
                pending_pixels.push_back(note_known ? note_want : shade);
            end
            if (pixel_valid && pixel_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel transfer %h", $time, pixel_data);
                    error_count++;
                end
                else
                begin
                    want       = pending_pixels.pop_front();
                    got_lanes  = pixel_data;
                    want_lanes = want;
                    for (int k = 3; k >= 0; k--)
                        if (got_lanes[k] !== want_lanes[k])
                        begin
                            $display("%0t: %s mismatch: expected %h, actual %h", $time,
                                     lane_names[k], want_lanes[k], got_lanes[k]);
                            error_count++;
                        end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("filled_shape_rasterizer_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int         rand_sent;
        int         pick;
        int         x, y, w, h, r;
        logic [2:0] shape_op;

        foreach (frame_img[i]) frame_img[i] = '0;

        // Fresh frame reads as zero
        add_row(make_cmd(fsr_pkg::OP_READ, 0, 0, 0, 0, 0, 32'h0), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 31, 31, 0, 0, 0, 32'h0), 1, 32'h0);
        // Extreme box covers the whole frame
        add_row(make_cmd(fsr_pkg::OP_RECT, -128, -128, 255, 255, 0, 32'hFFFF_FFFF), 1,
                32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 0, 0, 0, 0, 0, 32'h0), 1, 32'hFFFF_FFFF);
        add_row(make_cmd(fsr_pkg::OP_READ, 31, 31, 0, 0, 0, 32'h0), 1, 32'hFFFF_FFFF);
        // Reads outside the frame answer zero
        add_row(make_cmd(fsr_pkg::OP_READ, -128, -128, 0, 0, 0, 32'h0), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 127, 127, 255, 255, 127, 32'hFFFF_FFFF), 1,
                32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 32, 0, 0, 0, 0, 32'h0), 1, 32'h0);
        // Unused opcodes change nothing
        add_row(make_cmd(OP_UNUSED_LO, 0, 0, 0, 0, 0, 32'h0), 1, 32'h0);
        add_row(make_cmd(OP_UNUSED_HI, -1, -1, 255, 255, 127, 32'hFFFF_FFFF), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 15, 15, 0, 0, 0, 32'h0), 1, 32'hFFFF_FFFF);
        add_row(make_cmd(fsr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 32'h0), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 31, 0, 0, 0, 0, 32'h0), 1, 32'h0);
        // Zero-width box draws nothing
        add_row(make_cmd(fsr_pkg::OP_RECT, 4, 4, 0, 10, 0, 32'h1234_5678), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 4, 4, 0, 0, 0, 32'h0), 1, 32'h0);
        // Radius zero covers the centre alone
        add_row(make_cmd(fsr_pkg::OP_CIRCLE, 10, 10, 0, 0, 0, 32'h1122_3344), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 10, 10, 0, 0, 0, 32'h0), 1, 32'h1122_3344);
        add_row(make_cmd(fsr_pkg::OP_READ, 11, 10, 0, 0, 0, 32'h0), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_CIRCLE, 127, 127, 0, 0, 127, 32'hA5C3_5A3C), 1,
                32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 31, 31, 0, 0, 0, 32'h0), 0, 32'h0);
        // Narrow rounded box: the cross box inset by r in x is empty, the other cross box and corner discs still drawn
        add_row(make_cmd(fsr_pkg::OP_ROUND, 2, 2, 3, 20, 4, 32'h0F0F_F0F0), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 6, 6, 0, 0, 0, 32'h0), 0, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_ROUND, -128, 10, 255, 15, 127, 32'h5555_AAAA), 1,
                32'h0);
        add_row(make_cmd(fsr_pkg::OP_ROUND, 16, 16, 12, 10, 3, 32'hC0DE_0001), 1, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 16, 16, 0, 0, 0, 32'h0), 0, 32'h0);
        add_row(make_cmd(fsr_pkg::OP_READ, 20, 20, 0, 0, 0, 32'h0), 0, 32'h0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_cmd(make_cmd(fsr_pkg::OP_CLEAR, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 127),
                                  $urandom()), 0, '0);
                rand_sent++;
            end
            else if (pick < 7)
            begin
                send_cmd(make_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 127), $urandom()), 0, '0);
                rand_sent++;
            end
            else if (pick < 14)
            begin
                // Read anywhere, mostly off the frame
                send_cmd(make_cmd(fsr_pkg::OP_READ, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 127),
                                  $urandom()), 0, '0);
                rand_sent++;
            end
            else
            begin
                // Draw a shape, then probe the frame a few times
                shape_op = 3'($urandom_range(fsr_pkg::OP_RECT, fsr_pkg::OP_ROUND));
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 255);
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 255);
                    r = $urandom_range(0, 127);
                end
                else
                begin
                    x = $urandom_range(0, 48) - 8;
                    y = $urandom_range(0, 48) - 8;
                    w = $urandom_range(0, 40);
                    h = $urandom_range(0, 40);
                    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 6);
                end
                send_cmd(make_cmd(shape_op, x, y, w, h, r, $urandom()), 0, '0);
                rand_sent++;
                repeat ($urandom_range(2, 8))
                begin
                    send_cmd(make_cmd(fsr_pkg::OP_READ, $urandom_range(0, SIDE-1),
                                      $urandom_range(0, SIDE-1), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 127),
                                      $urandom()), 0, '0);
                    rand_sent++;
                end
            end
        end

        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("filled_shape_rasterizer_unit_tb: PASS");
        else
            $display("filled_shape_rasterizer_unit_tb: FAIL");
        $finish;
    end

endmodule
